// ===== sv/opm_pkg.sv =====
// Shared types, constants and cell merge function for the occupancy patch merge block.
// No dependencies.
package opm_pkg;

  localparam logic [15:0] HiBitsMask = 16'hAAAA;
  localparam logic [15:0] LoBitsMask = 16'h5555;
  localparam logic [9:0]  PatchSizeCells = 10'd16;

  typedef struct packed {
    logic [15:0] patch_word;
    logic [10:0] word_address;
    logic        placement_error;
    logic        in_range;
  } opm_cmd_t;

  typedef struct packed {
    logic [15:0] merged_word;
    logic [10:0] word_address;
    logic        placement_error;
  } opm_res_t;

  function automatic logic [15:0] cell_merge(logic [15:0] stored, logic [15:0] incoming);
    logic [15:0] known;
    known = incoming | ((incoming & HiBitsMask) >> 1) | ((incoming & LoBitsMask) << 1);
    return (stored & ~known) | incoming;
  endfunction

endpackage

// ===== sv/occupancy_patch_merge.sv =====
// Occupancy patch merge: top level joining front end, command queue, back end and result queue.
// Depends on opm_pkg, opm_front, opm_fifo and opm_back.
//
// Usage:
//   Input channel: push/full. A patch word is taken at a clock edge with push high and
//   full low. Each word is merged into the 2-bit-cell map word it covers; nonzero cells
//   replace stored ones, zero cells keep them.
//   Result channel: empty/pop. While empty is low the oldest result is on merged_word_o,
//   word_address_o and placement_error_o; it leaves at an edge with pop high.
//   A misaligned or out-of-map origin sets placement_error_o and leaves the map unchanged.
// Path: command queue, then map read, then result queue.
// Throughput: one item per cycle while the result queue has room; the map memory has one
//   read and one write port and the last written word is forwarded to a following
//   read-modify-write of the same word.
// Reset: the map is swept to zero, one word per cycle, over every map word; full stays high
//   during the sweep.
// Stall: when the receiver does not pop, the result queue fills, the back end holds its
//   word, the command queue fills and full rises.
module occupancy_patch_merge
  import opm_pkg::*;
#(
  parameter int MAP_WIDTH_CELLS  = 128,
  parameter int MAP_HEIGHT_CELLS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [6:0]  origin_x_i,
  input  logic [6:0]  origin_y_i,
  input  logic [4:0]  patch_word_index_i,
  input  logic [15:0] patch_word_i,
  input  logic        pop,
  output logic        empty,
  output logic [15:0] merged_word_o,
  output logic [10:0] word_address_o,
  output logic        placement_error_o
);

  localparam int MapWords = (MAP_WIDTH_CELLS / 4) * (MAP_HEIGHT_CELLS / 2);
  localparam int IdxW     = $clog2(MapWords);
  localparam int CmdW     = $bits(opm_cmd_t) + IdxW;

  opm_cmd_t        f_cmd, q_cmd;
  logic [IdxW-1:0] f_idx, q_idx;
  logic            cmd_full, cmd_empty, cmd_pop, clearing;
  logic            res_push, res_full;
  opm_res_t        b_res, o_res;

  assign full = cmd_full || clearing;

  opm_front #(
    .MAP_WIDTH_CELLS (MAP_WIDTH_CELLS),
    .MAP_HEIGHT_CELLS(MAP_HEIGHT_CELLS)
  ) u_front (
    .origin_x_i        (origin_x_i),
    .origin_y_i        (origin_y_i),
    .patch_word_index_i(patch_word_index_i),
    .patch_word_i      (patch_word_i),
    .cmd_o             (f_cmd),
    .ram_idx_o         (f_idx)
  );

  opm_fifo #(
    .Width(CmdW),
    .Depth(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full),
    .data_i ({f_cmd, f_idx}),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o ({q_cmd, q_idx})
  );

  opm_back #(
    .MAP_WIDTH_CELLS (MAP_WIDTH_CELLS),
    .MAP_HEIGHT_CELLS(MAP_HEIGHT_CELLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (q_cmd),
    .cmd_idx_i  (q_idx),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (b_res),
    .res_full_i (res_full),
    .clearing_o (clearing)
  );

  opm_fifo #(
    .Width($bits(opm_res_t)),
    .Depth(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (b_res),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (o_res)
  );

  assign merged_word_o     = o_res.merged_word;
  assign word_address_o    = o_res.word_address;
  assign placement_error_o = o_res.placement_error;

endmodule

// ===== sv/opm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Read returns the old word when the same address is written in the same cycle.
module opm_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/opm_fifo.sv =====
// Generic register FIFO with full/empty flags.
// Used for the command queue and the result queue; no package dependencies.
module opm_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == DepthC);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/opm_front.sv =====
// Front end: takes one patch word, checks placement and forms the map address.
// Depends on opm_pkg.
module opm_front
  import opm_pkg::*;
#(
  parameter int MAP_WIDTH_CELLS  = 128,
  parameter int MAP_HEIGHT_CELLS = 128
) (
  input  logic [6:0]  origin_x_i,
  input  logic [6:0]  origin_y_i,
  input  logic [4:0]  patch_word_index_i,
  input  logic [15:0] patch_word_i,
  output opm_cmd_t    cmd_o,
  output logic [$clog2(MAP_WIDTH_CELLS / 4 * (MAP_HEIGHT_CELLS / 2))-1:0] ram_idx_o
);

  localparam int WordsPerBand = MAP_WIDTH_CELLS / 4;
  localparam int MapWords     = WordsPerBand * (MAP_HEIGHT_CELLS / 2);
  localparam int IdxW         = $clog2(MapWords);
  localparam int CalcW        = 9 + $clog2(WordsPerBand);
  localparam logic [9:0] MapW = 10'(MAP_WIDTH_CELLS);
  localparam logic [9:0] MapH = 10'(MAP_HEIGHT_CELLS);

  logic [5:0]       x_word;
  logic [6:0]       row;
  logic [CalcW-1:0] addr;
  logic             misaligned, x_over, y_over;

  always_comb begin
    x_word     = {1'b0, origin_x_i[6:2]} + {4'b0, patch_word_index_i[1:0]};
    row        = {1'b0, origin_y_i[6:1]} + {4'b0, patch_word_index_i[4:2]};
    addr       = CalcW'(x_word) + CalcW'(CalcW'(row) * CalcW'(WordsPerBand));
    misaligned = (origin_x_i[1:0] != 2'b00) || origin_y_i[0];
    x_over     = ({3'b0, origin_x_i} + PatchSizeCells) > MapW;
    y_over     = ({3'b0, origin_y_i} + PatchSizeCells) > MapH;

    cmd_o.patch_word      = patch_word_i;
    cmd_o.word_address    = addr[10:0];
    cmd_o.in_range        = 32'(addr) < 32'(MapWords);
    cmd_o.placement_error = misaligned || x_over || y_over || !cmd_o.in_range;
    ram_idx_o             = addr[IdxW-1:0];
  end

endmodule

// ===== sv/opm_back.sv =====
// Back end: clears map after reset; read-modify-write if no placement error.
// Depends on opm_pkg and opm_ram.
module opm_back
  import opm_pkg::*;
#(
  parameter int MAP_WIDTH_CELLS  = 128,
  parameter int MAP_HEIGHT_CELLS = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  opm_cmd_t cmd_i,
  input  logic [$clog2(MAP_WIDTH_CELLS / 4 * (MAP_HEIGHT_CELLS / 2))-1:0] cmd_idx_i,
  output logic     cmd_pop_o,
  output logic     res_push_o,
  output opm_res_t res_o,
  input  logic     res_full_i,
  output logic     clearing_o
);

  localparam int MapWords = (MAP_WIDTH_CELLS / 4) * (MAP_HEIGHT_CELLS / 2);
  localparam int IdxW     = $clog2(MapWords);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MapWords - 1);

  logic            clear_q;
  logic [IdxW-1:0] clr_idx_q;
  logic            m_valid_q;
  opm_cmd_t        m_cmd_q;
  logic [IdxW-1:0] m_idx_q;
  logic            fwd_valid_q;
  logic [IdxW-1:0] fwd_idx_q;
  logic [15:0]     fwd_data_q;

  logic            m_adv, take, m_write, ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [15:0]     ram_wdata, rdata, stored, merged;

  assign clearing_o = clear_q;
  assign m_adv      = m_valid_q && !res_full_i;
  assign take       = cmd_valid_i && !clear_q && (!m_valid_q || m_adv);
  assign cmd_pop_o  = take;
  assign m_write    = m_adv && !m_cmd_q.placement_error;

  always_comb begin
    stored = (fwd_valid_q && (fwd_idx_q == m_idx_q)) ? fwd_data_q : rdata;
    merged = cell_merge(stored, m_cmd_q.patch_word);
    res_o.word_address    = m_cmd_q.word_address;
    res_o.placement_error = m_cmd_q.placement_error;
    if (!m_cmd_q.placement_error) begin
      res_o.merged_word = merged;
    end else if (m_cmd_q.in_range) begin
      res_o.merged_word = stored;
    end else begin
      res_o.merged_word = '0;
    end
    res_push_o = m_adv;

    ram_we    = clear_q || m_write;
    ram_waddr = clear_q ? clr_idx_q : m_idx_q;
    ram_wdata = clear_q ? 16'h0000 : merged;
  end

  opm_ram #(
    .Width(16),
    .Depth(MapWords)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (take),
    .raddr_i(cmd_idx_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b1;
      clr_idx_q   <= '0;
      m_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (clear_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == LastIdx) begin
          clear_q <= 1'b0;
        end
      end
      if (take) begin
        m_valid_q <= 1'b1;
      end else if (m_adv) begin
        m_valid_q <= 1'b0;
      end
      if (m_write) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      m_cmd_q <= cmd_i;
      m_idx_q <= cmd_idx_i;
    end
    if (m_write) begin
      fwd_idx_q  <= m_idx_q;
      fwd_data_q <= merged;
    end
  end

endmodule
